/* hdl/rgb_to_hsv_core_assert.svh */
`ifndef RGB_TO_HSV_CORE_ASSERT_SVH
`define RGB_TO_HSV_CORE_ASSERT_SVH

// Checked outside reset.
`define RTH_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked during reset as well.
`define RTH_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

/* hdl/rth_pkg.sv */
package rth_pkg;

  localparam int unsigned CH_W          = 8;
  localparam int unsigned HUE_W         = 15;
  localparam int unsigned SAT_W         = 8;
  localparam int unsigned HUE_FRAC_BITS = 6;

  // sector offset numerator, below 6 * 255
  localparam int unsigned M_W        = 11;
  // divisors are 2*diff and 2*max
  localparam int unsigned DIV_W      = CH_W + 1;
  // 2*255*diff + max
  localparam int unsigned SAT_REM_W  = 17;
  localparam int unsigned SAT_SCALE2 = 510;
  localparam int unsigned HUE_DEG    = 60;
  localparam int unsigned HUE_CIRCLE = 360;

  typedef struct packed {
    logic [CH_W-1:0] hi;
    logic [CH_W-1:0] diff;
  } side_t;

  function automatic int unsigned hue_full(int unsigned frac_bits);
    return HUE_CIRCLE * (32'd1 << frac_bits);
  endfunction

  function automatic int unsigned hue_qw(int unsigned frac_bits);
    return $clog2(hue_full(frac_bits) + 1);
  endfunction

  // 2*N + d with N = 60*S*m, m below 1530
  function automatic int unsigned hue_rem_w(int unsigned frac_bits);
    return $clog2(2 * HUE_DEG * (32'd1 << frac_bits) * 1530 + 256);
  endfunction

endpackage

/* hdl/rth_if.sv */
interface rth_pix_if;
  import rth_pkg::*;
  logic            valid;
  logic            ready;
  logic [CH_W-1:0] red;
  logic [CH_W-1:0] green;
  logic [CH_W-1:0] blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

interface rth_hsv_if;
  import rth_pkg::*;
  logic             valid;
  logic             ready;
  logic [HUE_W-1:0] hue;
  logic [SAT_W-1:0] saturation;
  logic [CH_W-1:0]  brightness;

  modport source (output valid, output hue, output saturation, output brightness,
                  input ready);
  modport sink   (input valid, input hue, input saturation, input brightness,
                  output ready);
endinterface

/* hdl/rth_front.sv */
module rth_front #(
  parameter int unsigned HueFracBits = rth_pkg::HUE_FRAC_BITS
) (
  input  logic                                            clk_i,
  input  logic                                            en_a_i,
  input  logic                                            en_b_i,
  input  logic [rth_pkg::CH_W-1:0]                        red_i,
  input  logic [rth_pkg::CH_W-1:0]                        green_i,
  input  logic [rth_pkg::CH_W-1:0]                        blue_i,
  output logic [rth_pkg::hue_rem_w(HueFracBits)-1:0]      hue_rem_o,
  output logic [rth_pkg::SAT_REM_W-1:0]                   sat_rem_o,
  output rth_pkg::side_t                                  side_o
);
  import rth_pkg::*;

  localparam int unsigned RemW    = hue_rem_w(HueFracBits);
  localparam int unsigned HueUnit = HUE_DEG * (32'd1 << HueFracBits);

  logic [CH_W-1:0] hi, lo, pos, neg, diff;
  logic [M_W-1:0]  base_d, m_d;

  logic [CH_W-1:0] hi_q, diff_q;
  logic [M_W-1:0]  m_q;

  logic [RemW-1:0]      n_prod, hue_rem_d;
  logic [SAT_REM_W-1:0] sat_rem_d;

  // stage A: max, min and sector offset numerator
  always_comb begin
    hi = red_i;
    if (green_i > hi) hi = green_i;
    if (blue_i > hi) hi = blue_i;
    lo = red_i;
    if (green_i < lo) lo = green_i;
    if (blue_i < lo) lo = blue_i;
    diff = hi - lo;
    if (hi == red_i) begin
      pos = green_i;
      neg = blue_i;
      if (green_i >= blue_i) begin
        base_d = '0;
      end else begin
        base_d = (M_W'(diff) << 2) + (M_W'(diff) << 1);
      end
    end else if (hi == green_i) begin
      pos    = blue_i;
      neg    = red_i;
      base_d = M_W'(diff) << 1;
    end else begin
      pos    = red_i;
      neg    = green_i;
      base_d = M_W'(diff) << 2;
    end
    m_d = base_d + M_W'(pos) - M_W'(neg);
  end

  always_ff @(posedge clk_i) begin
    if (en_a_i) begin
      hi_q   <= hi;
      diff_q <= diff;
      m_q    <= m_d;
    end
  end

  // stage B: rounded dividends
  always_comb begin
    n_prod    = RemW'(m_q) * RemW'(HueUnit);
    hue_rem_d = (n_prod << 1) + RemW'(diff_q);
    sat_rem_d = SAT_REM_W'(diff_q) * SAT_REM_W'(SAT_SCALE2) + SAT_REM_W'(hi_q);
  end

  always_ff @(posedge clk_i) begin
    if (en_b_i) begin
      hue_rem_o <= hue_rem_d;
      sat_rem_o <= sat_rem_d;
      side_o    <= '{hi: hi_q, diff: diff_q};
    end
  end

endmodule

/* hdl/rth_div_cell.sv */
module rth_div_cell #(
  parameter int unsigned RemW   = 24,
  parameter int unsigned QuoW   = 15,
  parameter int unsigned HueIdx = 0,
  parameter bit          SatEn  = 1'b0,
  parameter int unsigned SatIdx = 0
) (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  logic [RemW-1:0]               hue_rem_i,
  input  logic [QuoW-1:0]               hue_quo_i,
  input  logic [rth_pkg::SAT_REM_W-1:0] sat_rem_i,
  input  logic [rth_pkg::SAT_W-1:0]     sat_quo_i,
  input  rth_pkg::side_t                side_i,
  output logic [RemW-1:0]               hue_rem_o,
  output logic [QuoW-1:0]               hue_quo_o,
  output logic [rth_pkg::SAT_REM_W-1:0] sat_rem_o,
  output logic [rth_pkg::SAT_W-1:0]     sat_quo_o,
  output rth_pkg::side_t                side_o
);
  import rth_pkg::*;

  localparam int unsigned HueCmpW = RemW + DIV_W;
  localparam int unsigned SatCmpW = SAT_REM_W + DIV_W;

  logic [HueCmpW-1:0]   hue_ext, hue_dsh, hue_sub;
  logic                 hue_bit;
  logic [RemW-1:0]      hue_rem_d;
  logic [QuoW-1:0]      hue_quo_d;
  logic [SAT_REM_W-1:0] sat_rem_d;
  logic [SAT_W-1:0]     sat_quo_d;

  // one restoring step on the hue quotient
  always_comb begin
    hue_ext   = HueCmpW'(hue_rem_i);
    hue_dsh   = HueCmpW'({side_i.diff, 1'b0}) << HueIdx;
    hue_bit   = hue_ext >= hue_dsh;
    hue_sub   = hue_bit ? (hue_ext - hue_dsh) : hue_ext;
    hue_rem_d = hue_sub[RemW-1:0];
    hue_quo_d = hue_quo_i;
    hue_quo_d[HueIdx] = hue_bit;
  end

  if (SatEn) begin : g_sat
    logic [SatCmpW-1:0] sat_ext, sat_dsh, sat_sub;
    logic               sat_bit;

    always_comb begin
      sat_ext   = SatCmpW'(sat_rem_i);
      sat_dsh   = SatCmpW'({side_i.hi, 1'b0}) << SatIdx;
      sat_bit   = sat_ext >= sat_dsh;
      sat_sub   = sat_bit ? (sat_ext - sat_dsh) : sat_ext;
      sat_rem_d = sat_sub[SAT_REM_W-1:0];
      sat_quo_d = sat_quo_i;
      sat_quo_d[SatIdx] = sat_bit;
    end
  end else begin : g_nosat
    always_comb begin
      sat_rem_d = sat_rem_i;
      sat_quo_d = sat_quo_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      hue_rem_o <= hue_rem_d;
      hue_quo_o <= hue_quo_d;
      sat_rem_o <= sat_rem_d;
      sat_quo_o <= sat_quo_d;
      side_o    <= side_i;
    end
  end

endmodule

/* hdl/rgb_to_hsv_core.sv */
// RGB to HSV converter, one RGB pixel of 8-bit channels in, one HSV result out.
// pix_i: sink channel carrying red, green, blue; a request is taken on a
// clock edge with valid and ready both high.
// hsv_o: source channel carrying hue (1/2^HueFracBits degree units),
// saturation (255 = 1.0) and brightness (largest channel).
// HueQW = clog2(360 * 2^HueFracBits + 1) is the hue quotient width.
// Two front stages form max/min and the rounded dividends, then a chain
// of HueQW divider cells resolves one hue quotient bit each (the last 8
// cells also one saturation bit each), then an output stage wraps hue.
// Throughput: one pixel per cycle while hsv_o is ready.
// Each stage advances when the stage after it is empty or advancing, so
// a stall on hsv_o fills the empty stages first; pix_i.ready falls only
// once every stage holds a pixel. A held result keeps its payload.
// Reset clears all stage valid flags, so the block is ready for a pixel
// as soon as reset is released.
module rgb_to_hsv_core #(
  parameter int unsigned HueFracBits = rth_pkg::HUE_FRAC_BITS
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  rth_pix_if.sink    pix_i,
  rth_hsv_if.source  hsv_o
);
  import rth_pkg::*;
  `include "rgb_to_hsv_core_assert.svh"

  localparam int unsigned HueFull = hue_full(HueFracBits);
  localparam int unsigned HueQW   = hue_qw(HueFracBits);
  localparam int unsigned RemW    = hue_rem_w(HueFracBits);
  localparam int unsigned NC      = HueQW;
  localparam int unsigned NS      = NC + 3;
  localparam int unsigned OutW    = (HueQW > HUE_W) ? HueQW : HUE_W;
  localparam logic [HueQW-1:0] HueFullQ = HueQW'(HueFull);

  logic [NS-1:0] v_q, v_d, en;

  logic [RemW-1:0]      hue_rem [NC+1];
  logic [HueQW-1:0]     hue_quo [NC+1];
  logic [SAT_REM_W-1:0] sat_rem [NC+1];
  logic [SAT_W-1:0]     sat_quo [NC+1];
  side_t                side    [NC+1];

  logic [HueQW-1:0] hue_wrap;
  logic [OutW-1:0]  hue_ext;
  logic             gray;
  logic [HUE_W-1:0] hue_q, hue_d;
  logic [SAT_W-1:0] sat_q, sat_d;
  logic [CH_W-1:0]  bri_q;

  // a stage loads when it or any stage after it is empty, or output drains
  always_comb begin
    for (int j = 0; j < NS; j++) begin
      en[j] = hsv_o.ready | ~&(v_q | NS'((64'd1 << j) - 64'd1));
    end
    for (int j = 0; j < NS; j++) begin
      if (en[j]) begin
        v_d[j] = (j == 0) ? pix_i.valid : v_q[(j == 0) ? 0 : j - 1];
      end else begin
        v_d[j] = v_q[j];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= v_d;
    end
  end

  assign pix_i.ready = en[0];

  rth_front #(
    .HueFracBits (HueFracBits)
  ) u_front (
    .clk_i     (clk_i),
    .en_a_i    (en[0]),
    .en_b_i    (en[1]),
    .red_i     (pix_i.red),
    .green_i   (pix_i.green),
    .blue_i    (pix_i.blue),
    .hue_rem_o (hue_rem[0]),
    .sat_rem_o (sat_rem[0]),
    .side_o    (side[0])
  );

  assign hue_quo[0] = '0;
  assign sat_quo[0] = '0;

  for (genvar k = 0; k < NC; k++) begin : g_cell
    rth_div_cell #(
      .RemW   (RemW),
      .QuoW   (HueQW),
      .HueIdx (NC - 1 - k),
      .SatEn  (k >= NC - SAT_W),
      .SatIdx ((k >= NC - SAT_W) ? (NC - 1 - k) : 0)
    ) u_cell (
      .clk_i     (clk_i),
      .en_i      (en[k + 2]),
      .hue_rem_i (hue_rem[k]),
      .hue_quo_i (hue_quo[k]),
      .sat_rem_i (sat_rem[k]),
      .sat_quo_i (sat_quo[k]),
      .side_i    (side[k]),
      .hue_rem_o (hue_rem[k + 1]),
      .hue_quo_o (hue_quo[k + 1]),
      .sat_rem_o (sat_rem[k + 1]),
      .sat_quo_o (sat_quo[k + 1]),
      .side_o    (side[k + 1])
    );
  end

  // gray pixels force zero; a full circle wraps to zero
  always_comb begin
    gray     = side[NC].diff == '0;
    hue_wrap = (hue_quo[NC] >= HueFullQ) ? (hue_quo[NC] - HueFullQ) : hue_quo[NC];
    hue_ext  = OutW'(hue_wrap);
    hue_d    = gray ? '0 : hue_ext[HUE_W-1:0];
    sat_d    = gray ? '0 : sat_quo[NC];
  end

  always_ff @(posedge clk_i) begin
    if (en[NS-1]) begin
      hue_q <= hue_d;
      sat_q <= sat_d;
      bri_q <= side[NC].hi;
    end
  end

  assign hsv_o.valid      = v_q[NS-1];
  assign hsv_o.hue        = hue_q;
  assign hsv_o.saturation = sat_q;
  assign hsv_o.brightness = bri_q;

  `RTH_ASSERT_RST(a_rst_empty, !rst_ni |-> (v_q == '0), "pipeline not empty in reset")
  `RTH_ASSERT(a_empty_ready, (v_q == '0) |-> pix_i.ready, "empty pipeline refuses request")
  `RTH_ASSERT(a_accept_lands, (pix_i.valid && pix_i.ready) |=> v_q[0], "accepted pixel lost")
  `RTH_ASSERT(a_hue_range, v_q[NS-2] |-> (gray || (hue_wrap < HueFullQ)), "hue out of range")
  `RTH_ASSERT(a_gray_hue, (hsv_o.valid && (hsv_o.saturation == '0)) |-> (hsv_o.hue == '0), "zero saturation with nonzero hue")

endmodule

/* tb/sv/rth_hsv_checker.sv */
`timescale 1ns / 1ps

module rth_hsv_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  rth_pix_if          pix_mon,
  rth_hsv_if          hsv_mon,
  output int unsigned mismatch_cnt_o,
  output int unsigned pending_o,
  output int unsigned checked_o
);
  import rth_pkg::*;

  typedef struct packed {
    logic [HUE_W-1:0] hue;
    logic [SAT_W-1:0] saturation;
    logic [CH_W-1:0]  brightness;
  } hsv_t;

  function automatic hsv_t hsv_of_pixel(logic [CH_W-1:0] r, logic [CH_W-1:0] g,
                                        logic [CH_W-1:0] b);
    int   hi;
    int   lo;
    int   diff;
    int   base;
    int   offs;
    int   num;
    int   hue;
    int   circle;
    hsv_t res;
    hi = int'(r);
    lo = int'(r);
    if (int'(g) > hi) hi = int'(g);
    if (int'(b) > hi) hi = int'(b);
    if (int'(g) < lo) lo = int'(g);
    if (int'(b) < lo) lo = int'(b);
    diff   = hi - lo;
    circle = HUE_CIRCLE * (1 << HUE_FRAC_BITS);
    res    = '0;
    res.brightness = CH_W'(hi);
    if (diff != 0) begin
      // red wins ties over green, green over blue
      if (hi == int'(r)) begin
        offs = int'(g) - int'(b);
        base = (g >= b) ? 0 : 6;
      end else if (hi == int'(g)) begin
        offs = int'(b) - int'(r);
        base = 2;
      end else begin
        offs = int'(r) - int'(g);
        base = 4;
      end
      num = (base * diff + offs) * HUE_DEG * (1 << HUE_FRAC_BITS);
      hue = (2 * num + diff) / (2 * diff);
      if (hue >= circle) hue = hue - circle;
      res.hue        = HUE_W'(hue);
      res.saturation = SAT_W'((SAT_SCALE2 * diff + hi) / (2 * hi));
    end
    return res;
  endfunction

  hsv_t        hsv_expected_q[$];
  hsv_t        want;
  int unsigned mismatches;
  int unsigned checked;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hsv_expected_q.delete();
      mismatches     = 0;
      checked        = 0;
      mismatch_cnt_o <= 0;
      pending_o      <= 0;
      checked_o      <= 0;
    end else begin
      if (pix_mon.valid && pix_mon.ready) begin
        hsv_expected_q.push_back(hsv_of_pixel(pix_mon.red, pix_mon.green, pix_mon.blue));
      end
      if (hsv_mon.valid && hsv_mon.ready) begin
        if (hsv_expected_q.size() == 0) begin
          $error("HSV result with no pending request");
          mismatches++;
        end else begin
          want = hsv_expected_q.pop_front();
          checked++;
          if (hsv_mon.hue !== want.hue) begin
            $error("hue: expected %0d, actual %0d", want.hue, hsv_mon.hue);
            mismatches++;
          end
          if (hsv_mon.saturation !== want.saturation) begin
            $error("saturation: expected %0d, actual %0d", want.saturation,
                   hsv_mon.saturation);
            mismatches++;
          end
          if (hsv_mon.brightness !== want.brightness) begin
            $error("brightness: expected %0d, actual %0d", want.brightness,
                   hsv_mon.brightness);
            mismatches++;
          end
        end
      end
      mismatch_cnt_o <= mismatches;
      pending_o      <= hsv_expected_q.size();
      checked_o      <= checked;
    end
  end

endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 1ps

module tb;
  import rth_pkg::*;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  bit          hold_req;
  int unsigned sent_cnt;
  int unsigned mismatch_cnt;
  int unsigned pending_cnt;
  int unsigned checked_cnt;

  logic [3*CH_W-1:0] directed_px [20] = '{
    24'h000000, 24'hFFFFFF, 24'h010101, 24'hFF0000, 24'h00FF00,
    24'h0000FF, 24'hFFFF00, 24'h00FFFF, 24'hFF00FF, 24'hFF0001,
    24'hFF0100, 24'h010000, 24'h000100, 24'h000001, 24'h807F81,
    24'hC8C8C7, 24'h0AFF0A, 24'hFF8080, 24'h7F80C8, 24'h55AAFF
  };

  always #5 clk_i = ~clk_i;

  rth_pix_if pix_if ();
  rth_hsv_if hsv_if ();

  rgb_to_hsv_core uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .pix_i  (pix_if),
    .hsv_o  (hsv_if)
  );

  rth_hsv_checker hsv_check (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .pix_mon        (pix_if),
    .hsv_mon        (hsv_if),
    .mismatch_cnt_o (mismatch_cnt),
    .pending_o      (pending_cnt),
    .checked_o      (checked_cnt)
  );

  function automatic logic [CH_W-1:0] edge_channel();
    case ($urandom_range(4))
      0: begin
        return 8'h00;
      end
      1: begin
        return 8'h01;
      end
      2: begin
        return 8'hFE;
      end
      3: begin
        return 8'hFF;
      end
      default: begin
        return CH_W'($urandom);
      end
    endcase
  endfunction

  task automatic random_pixel(output logic [CH_W-1:0] r, output logic [CH_W-1:0] g,
                              output logic [CH_W-1:0] b);
    int unsigned     kind;
    logic [CH_W-1:0] m;
    logic [CH_W-1:0] v;
    kind = $urandom_range(99);
    m = CH_W'($urandom);
    v = CH_W'($urandom_range(int'(m)));
    r = CH_W'($urandom);
    g = CH_W'($urandom);
    b = CH_W'($urandom);
    if (kind < 10) begin
      r = m;
      g = m;
      b = m;
    end else if (kind < 22) begin
      // two channels tied at the maximum
      case ($urandom_range(2))
        0: begin
          r = m; g = m; b = v;
        end
        1: begin
          g = m; b = m; r = v;
        end
        default: begin
          r = m; b = m; g = v;
        end
      endcase
    end else if (kind < 32) begin
      r = edge_channel();
      g = edge_channel();
      b = edge_channel();
    end else if (kind < 40) begin
      r = m;
      g = m ^ CH_W'($urandom_range(1));
      b = m ^ CH_W'($urandom_range(3));
    end
  endtask

  task automatic send_pixel(input logic [CH_W-1:0] r, input logic [CH_W-1:0] g,
                            input logic [CH_W-1:0] b);
    logic rdy;
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      pix_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    pix_if.valid <= 1'b1;
    pix_if.red   <= r;
    pix_if.green <= g;
    pix_if.blue  <= b;
    do begin
      @(negedge clk_i);
      rdy = pix_if.ready;
      @(posedge clk_i);
    end while (!rdy);
    sent_cnt++;
  endtask

  task automatic run_phase(input int unsigned n, input int unsigned idle_pct,
                           input int unsigned stall_pct);
    logic [CH_W-1:0] r;
    logic [CH_W-1:0] g;
    logic [CH_W-1:0] b;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (n) begin
      random_pixel(r, g, b);
      send_pixel(r, g, b);
    end
  endtask

  // receiver side; a hold request keeps ready low for a long stretch
  initial begin
    hsv_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        hsv_if.ready <= 1'b0;
        repeat (300) @(posedge clk_i);
      end
      hsv_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  initial begin
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_req       = 1'b0;
    sent_cnt       = 0;
    rst_ni       <= 1'b0;
    pix_if.valid <= 1'b0;
    pix_if.red   <= '0;
    pix_if.green <= '0;
    pix_if.blue  <= '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_px[i]) begin
      send_pixel(directed_px[i][23:16], directed_px[i][15:8], directed_px[i][7:0]);
    end

    hold_req = 1'b1;
    run_phase(500, 0, 0);
    run_phase(480, 66, 0);
    run_phase(480, 0, 66);
    run_phase(480, 31, 31);

    pix_if.valid   <= 1'b0;
    recv_stall_pct = 0;
    @(posedge clk_i);
    while (pending_cnt != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);

    $display("Sent %0d pixels: extremes, gray, tied maxima and random, under four idle mixes",
             sent_cnt);
    $display("Compared %0d HSV results, including a long output hold-off", checked_cnt);
    if (mismatch_cnt == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #1ms;
    $display("Timeout with %0d results still pending", pending_cnt);
    $display("Mismatches found");
    $finish;
  end

endmodule

/* filelist.f */
+incdir+hdl
hdl/rth_pkg.sv
hdl/rth_if.sv
hdl/rth_front.sv
hdl/rth_div_cell.sv
hdl/rgb_to_hsv_core.sv
tb/sv/rth_hsv_checker.sv
tb/sv/tb.sv
